// File: rtl/bas_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the button and auxiliary page selector.
// No dependencies; used by the channel interfaces and the top level.
package bas_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGNOSTICS_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_ENABLED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ENTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_EXIT = 3'd6;

  // Register reset values.
  localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd30;
  localparam logic [15:0] SHORT_PRESS_MAX_RST = 16'd800;
  localparam logic [15:0] BRIGHTNESS_MIN_RST = 16'd2000;
  localparam logic [15:0] DIAGNOSTICS_MIN_RST = 16'd5000;
  localparam logic TOUCH_ENABLED_RST = 1'b0;
  localparam logic [14:0] ZONE_ENTER_RST = 15'd11469;  // 0.35 in Q1.15
  localparam logic [14:0] ZONE_EXIT_RST = 15'd8847;    // 0.27 in Q1.15

  // Page codes.
  localparam logic [1:0] PAGE_DASHBOARD = 2'd0;
  localparam logic [1:0] PAGE_FACE = 2'd1;
  localparam logic [1:0] PAGE_SHOWCASE = 2'd2;
  localparam logic [1:0] PAGE_NONE = 2'd3;

  // Auxiliary channel zones.
  typedef enum logic [1:0] {
    ZONE_UNKNOWN = 2'd0,
    ZONE_LOW     = 2'd1,
    ZONE_MID     = 2'd2,
    ZONE_HIGH    = 2'd3
  } zone_t;

  // One input tick.
  typedef struct packed {
    logic [31:0]        time_ms;
    logic               button_level;
    logic               touch_request;
    logic [1:0]         touch_target;
    logic               vehicle_valid;
    logic               radio_lost;
    logic signed [15:0] aux_position;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0] page;
    logic       brightness_pulse;
    logic       diagnostics_pulse;
    logic       aux_in_control;
    logic       button_stable;
  } out_item_t;

endpackage

// File: rtl/bas_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one input tick.
// Depends on bas_pkg for the payload type.
interface bas_in_if;
  logic              valid;
  logic              ready;
  bas_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bas_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one result.
// Depends on bas_pkg for the payload type.
interface bas_out_if;
  logic               valid;
  logic               ready;
  bas_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/button_aux_page_selector.sv
`timescale 1ns / 1ps
// Top level of the button and auxiliary-channel page selector.
// Depends on bas_pkg, bas_in_if and bas_out_if.

// One request is taken per clock cycle, sustained, and each gives exactly one result:
// the tick is registered in the input register, then one pass of compare and
// subtract logic updates the debounce, page and zone state and loads the result
// register. This one-pass state update is what sets the rate of one tick per cycle;
// a stalled result register holds the pipeline, and one tick can wait in the input
// register meanwhile. Configuration writes take effect at once and must only happen
// while no request is in flight.
module button_aux_page_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  bas_in_if.sink                            in_ch,
  bas_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [bas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bas_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic [15:0] debounce_time_r;
  logic [15:0] short_press_max_r;
  logic [15:0] brightness_min_r;
  logic [15:0] diagnostics_min_r;
  logic        touch_enabled_r;
  logic [14:0] zone_enter_r;
  logic [14:0] zone_exit_r;

  // Pipeline registers.
  logic               stage_valid_r;
  bas_pkg::in_item_t  stage_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  bas_pkg::out_item_t out_r;
  bas_pkg::out_item_t out_nxt;
  logic               advance;

  // Block state.
  logic [1:0]     page_r, page_nxt;
  bas_pkg::zone_t zone_r, zone_nxt;
  logic           raw_level_r, raw_level_nxt;
  logic           stable_level_r, stable_level_nxt;
  logic [31:0]    raw_change_time_r, raw_change_time_nxt;
  logic [31:0]    press_start_time_r, press_start_time_nxt;
  logic           aux_owner_r, aux_owner_nxt;

  // Working signals of the update pass.
  logic [31:0]        since_change;
  logic [31:0]        press_dur;
  logic               accept_edge;
  logic               bright;
  logic               diag;
  logic               short_press;
  logic [1:0]         page_cycled;
  logic signed [16:0] pos_s;
  logic signed [16:0] enter_s;
  logic signed [16:0] exit_s;
  bas_pkg::zone_t     zone_cand;
  logic [1:0]         zone_page;

  // Handshake: the tick register moves on when the result register is free or draining.
  assign advance      = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !stage_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r   <= bas_pkg::DEBOUNCE_TIME_RST;
      short_press_max_r <= bas_pkg::SHORT_PRESS_MAX_RST;
      brightness_min_r  <= bas_pkg::BRIGHTNESS_MIN_RST;
      diagnostics_min_r <= bas_pkg::DIAGNOSTICS_MIN_RST;
      touch_enabled_r   <= bas_pkg::TOUCH_ENABLED_RST;
      zone_enter_r      <= bas_pkg::ZONE_ENTER_RST;
      zone_exit_r       <= bas_pkg::ZONE_EXIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bas_pkg::REG_DEBOUNCE_TIME:   debounce_time_r   <= cfg_wdata;
        bas_pkg::REG_SHORT_PRESS_MAX: short_press_max_r <= cfg_wdata;
        bas_pkg::REG_BRIGHTNESS_MIN:  brightness_min_r  <= cfg_wdata;
        bas_pkg::REG_DIAGNOSTICS_MIN: diagnostics_min_r <= cfg_wdata;
        bas_pkg::REG_TOUCH_ENABLED:   touch_enabled_r   <= cfg_wdata[0];
        bas_pkg::REG_ZONE_ENTER:      zone_enter_r      <= cfg_wdata[14:0];
        bas_pkg::REG_ZONE_EXIT:       zone_exit_r       <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Button sampling and debounce.
  always_comb begin
    raw_level_nxt       = stage_r.button_level;
    raw_change_time_nxt = (stage_r.button_level != raw_level_r) ? stage_r.time_ms
                                                                : raw_change_time_r;
    since_change = stage_r.time_ms - raw_change_time_nxt;
    accept_edge  = (raw_level_nxt != stable_level_r) &&
                   (since_change >= {16'd0, debounce_time_r});
    press_dur    = raw_change_time_nxt - press_start_time_r;

    stable_level_nxt     = stable_level_r;
    press_start_time_nxt = press_start_time_r;
    bright      = 1'b0;
    diag        = 1'b0;
    short_press = 1'b0;
    if (accept_edge) begin
      stable_level_nxt = raw_level_nxt;
      if (raw_level_nxt) begin
        press_start_time_nxt = raw_change_time_nxt;
      end else if (press_dur >= {16'd0, diagnostics_min_r}) begin
        diag = 1'b1;
      end else if (press_dur >= {16'd0, brightness_min_r}) begin
        bright = 1'b1;
      end else if ((press_dur >= {16'd0, debounce_time_r}) &&
                   (press_dur <= {16'd0, short_press_max_r})) begin
        short_press = 1'b1;
      end
    end
  end

  // Next page in the cycle, modulo three.
  always_comb begin
    unique case (page_r)
      bas_pkg::PAGE_DASHBOARD: page_cycled = bas_pkg::PAGE_FACE;
      bas_pkg::PAGE_FACE:      page_cycled = bas_pkg::PAGE_SHOWCASE;
      bas_pkg::PAGE_SHOWCASE:  page_cycled = bas_pkg::PAGE_DASHBOARD;
      default:                 page_cycled = bas_pkg::PAGE_FACE;
    endcase
  end

  // Zone classification with hysteresis.
  always_comb begin
    pos_s   = {stage_r.aux_position[15], stage_r.aux_position};
    enter_s = $signed({2'b00, zone_enter_r});
    exit_s  = $signed({2'b00, zone_exit_r});
    unique case (zone_r)
      bas_pkg::ZONE_LOW: begin
        if (pos_s >= enter_s) zone_cand = bas_pkg::ZONE_HIGH;
        else if (pos_s > -exit_s) zone_cand = bas_pkg::ZONE_MID;
        else zone_cand = bas_pkg::ZONE_LOW;
      end
      bas_pkg::ZONE_HIGH: begin
        if (pos_s <= -enter_s) zone_cand = bas_pkg::ZONE_LOW;
        else if (pos_s < exit_s) zone_cand = bas_pkg::ZONE_MID;
        else zone_cand = bas_pkg::ZONE_HIGH;
      end
      default: begin
        if (pos_s <= -enter_s) zone_cand = bas_pkg::ZONE_LOW;
        else if (pos_s >= enter_s) zone_cand = bas_pkg::ZONE_HIGH;
        else zone_cand = bas_pkg::ZONE_MID;
      end
    endcase
    unique case (zone_cand)
      bas_pkg::ZONE_LOW:  zone_page = bas_pkg::PAGE_DASHBOARD;
      bas_pkg::ZONE_HIGH: zone_page = bas_pkg::PAGE_SHOWCASE;
      default:            zone_page = bas_pkg::PAGE_FACE;
    endcase
  end

  // Page ownership: button, then touch, then the auxiliary channel; a later one overrides an earlier one.
  always_comb begin
    page_nxt      = page_r;
    zone_nxt      = zone_r;
    aux_owner_nxt = aux_owner_r;
    if (short_press && !aux_owner_r) begin
      page_nxt = page_cycled;
    end
    if (stage_r.touch_request && touch_enabled_r &&
        (stage_r.touch_target != bas_pkg::PAGE_NONE) && !aux_owner_r) begin
      page_nxt = stage_r.touch_target;
    end
    if (stage_r.vehicle_valid) begin
      if (stage_r.radio_lost) begin
        aux_owner_nxt = 1'b0;
      end else if (zone_r == bas_pkg::ZONE_UNKNOWN) begin
        zone_nxt = zone_cand;
        if (zone_cand != bas_pkg::ZONE_MID) begin
          aux_owner_nxt = 1'b1;
          page_nxt      = zone_page;
        end
      end else if (zone_cand != zone_r) begin
        zone_nxt      = zone_cand;
        aux_owner_nxt = 1'b1;
        page_nxt      = zone_page;
      end
    end
  end

  // Result assembly.
  always_comb begin
    out_nxt.page              = page_nxt;
    out_nxt.brightness_pulse  = bright;
    out_nxt.diagnostics_pulse = diag;
    out_nxt.aux_in_control    = aux_owner_nxt;
    out_nxt.button_stable     = stable_level_nxt;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r      <= 1'b0;
      out_valid_r        <= 1'b0;
      page_r             <= bas_pkg::PAGE_DASHBOARD;
      zone_r             <= bas_pkg::ZONE_UNKNOWN;
      raw_level_r        <= 1'b0;
      stable_level_r     <= 1'b0;
      raw_change_time_r  <= 32'd0;
      press_start_time_r <= 32'd0;
      aux_owner_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ch.ready) begin
        stage_valid_r <= in_ch.valid;
      end
      if (advance) begin
        page_r             <= page_nxt;
        zone_r             <= zone_nxt;
        raw_level_r        <= raw_level_nxt;
        stable_level_r     <= stable_level_nxt;
        raw_change_time_r  <= raw_change_time_nxt;
        press_start_time_r <= press_start_time_nxt;
        aux_owner_r        <= aux_owner_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_r <= in_ch.data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // Checks on the internal logic.
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.brightness_pulse && out_r.diagnostics_pulse))
    else $error("brightness and diagnostics pulses raised together");

  a_page_legal: assert property (@(posedge clk) disable iff (!rst_n)
    page_r != bas_pkg::PAGE_NONE)
    else $error("page register holds an illegal page");

  a_owner_needs_zone: assert property (@(posedge clk) disable iff (!rst_n)
    (zone_r == bas_pkg::ZONE_UNKNOWN) |-> !aux_owner_r)
    else $error("auxiliary channel owns the page without a known zone");

  a_pulse_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.brightness_pulse || out_r.diagnostics_pulse))
      |-> !out_r.button_stable)
    else $error("press pulse without a released button");

  a_stall_holds_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !advance) |=> (stage_valid_r && $stable(stage_r)))
    else $error("stalled tick lost from the input register");

endmodule

// File: dv/button_aux_page_selector_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for button_aux_page_selector: directed table, then random tick streams
// under several register settings, checked against an in-bench model or typed table rows.
// Depends on bas_pkg, bas_in_if, bas_out_if and the top level RTL.
module button_aux_page_selector_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT_TICK = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_TICKS = 260;
  localparam int PHASE_COUNT = 6;
  localparam int DRAIN_CYCLES = 8;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    bas_pkg::in_item_t  tick;
    logic               typed;
    bas_pkg::out_item_t want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bas_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bas_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bas_in_if  tick_ch ();
  bas_out_if result_ch ();

  button_aux_page_selector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Selector model state and its copy of the registers.
  logic [15:0]    debounce_ms;
  logic [15:0]    short_max_ms;
  logic [15:0]    bright_min_ms;
  logic [15:0]    diag_min_ms;
  logic           touch_on;
  int             enter_lvl;
  int             exit_lvl;
  logic [1:0]     sel_page;
  bas_pkg::zone_t sel_zone;
  logic           btn_raw;
  logic           btn_stable;
  logic [31:0]    raw_edge_ms;
  logic [31:0]    press_start_ms;
  logic           aux_owns;

  // Random stream generator state.
  logic [31:0] tick_now_ms;
  logic        plan_level;
  int          press_left;
  int          aux_last;

  bas_pkg::out_item_t screen_states_due[$];
  int                 fail_count = 0;
  int                 ticks_taken;
  int                 cycle_count = 0;
  int                 idle_pct;
  bit                 held_off = 1'b0;

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_aux_page_selector_tb failed");
      $finish;
    end
  end

  // Zone that a position moves to from the current zone, with hysteresis.
  function automatic bas_pkg::zone_t zone_after(int pos);
    if (sel_zone == bas_pkg::ZONE_LOW) begin
      if (pos >= enter_lvl) return bas_pkg::ZONE_HIGH;
      return (pos > -exit_lvl) ? bas_pkg::ZONE_MID : bas_pkg::ZONE_LOW;
    end
    if (sel_zone == bas_pkg::ZONE_HIGH) begin
      if (pos <= -enter_lvl) return bas_pkg::ZONE_LOW;
      return (pos < exit_lvl) ? bas_pkg::ZONE_MID : bas_pkg::ZONE_HIGH;
    end
    if (pos <= -enter_lvl) return bas_pkg::ZONE_LOW;
    if (pos >= enter_lvl) return bas_pkg::ZONE_HIGH;
    return bas_pkg::ZONE_MID;
  endfunction

  function automatic logic [1:0] page_of_zone(bas_pkg::zone_t z);
    if (z == bas_pkg::ZONE_LOW) return bas_pkg::PAGE_DASHBOARD;
    if (z == bas_pkg::ZONE_HIGH) return bas_pkg::PAGE_SHOWCASE;
    return bas_pkg::PAGE_FACE;
  endfunction

  // Advance the selector by one tick and return the screen state it reports.
  task automatic advance_selector(input bas_pkg::in_item_t t, output bas_pkg::out_item_t r);
    logic [31:0]    held_ms;
    logic [31:0]    press_ms;
    int             pos;
    bas_pkg::zone_t nz;
    r = '0;
    // Button sample first, then debounce and press classification.
    if (t.button_level != btn_raw) begin
      btn_raw = t.button_level;
      raw_edge_ms = t.time_ms;
    end
    held_ms = t.time_ms - raw_edge_ms;
    if (btn_raw != btn_stable && held_ms >= {16'd0, debounce_ms}) begin
      btn_stable = btn_raw;
      if (btn_stable) begin
        press_start_ms = raw_edge_ms;
      end else begin
        press_ms = raw_edge_ms - press_start_ms;
        if (press_ms >= {16'd0, diag_min_ms}) begin
          r.diagnostics_pulse = 1'b1;
        end else if (press_ms >= {16'd0, bright_min_ms}) begin
          r.brightness_pulse = 1'b1;
        end else if (press_ms >= {16'd0, debounce_ms} && press_ms <= {16'd0, short_max_ms}
                     && !aux_owns) begin
          sel_page = (sel_page == bas_pkg::PAGE_SHOWCASE) ? bas_pkg::PAGE_DASHBOARD
                                                          : sel_page + 2'd1;
        end
      end
    end
    // Touch request, honored only when enabled and the aux channel does not own the page.
    if (t.touch_request && touch_on && t.touch_target != bas_pkg::PAGE_NONE && !aux_owns) begin
      sel_page = t.touch_target;
    end
    // Auxiliary channel zones and ownership.
    if (t.vehicle_valid) begin
      pos = int'($signed(t.aux_position));
      nz = zone_after(pos);
      if (t.radio_lost) begin
        aux_owns = 1'b0;
      end else if (sel_zone == bas_pkg::ZONE_UNKNOWN) begin
        sel_zone = nz;
        if (nz != bas_pkg::ZONE_MID) begin
          aux_owns = 1'b1;
          sel_page = page_of_zone(nz);
        end
      end else if (nz != sel_zone) begin
        sel_zone = nz;
        aux_owns = 1'b1;
        sel_page = page_of_zone(nz);
      end
    end
    r.page = sel_page;
    r.aux_in_control = aux_owns;
    r.button_stable = btn_stable;
  endtask

  function automatic dir_row_t row(logic [31:0] ms, logic btn, logic treq, logic [1:0] tgt,
                                   logic vv, logic lost, logic signed [15:0] pos,
                                   logic typed = 1'b0,
                                   logic [1:0] page = bas_pkg::PAGE_DASHBOARD,
                                   logic br = 1'b0, logic dg = 1'b0, logic aux = 1'b0,
                                   logic stb = 1'b0);
    dir_row_t d;
    d.tick = '{time_ms: ms, button_level: btn, touch_request: treq, touch_target: tgt,
               vehicle_valid: vv, radio_lost: lost, aux_position: pos};
    d.typed = typed;
    d.want = '{page: page, brightness_pulse: br, diagnostics_pulse: dg,
               aux_in_control: aux, button_stable: stb};
    return d;
  endfunction

  // Offer one tick until it is taken, record its expected screen state, then maybe idle.
  task automatic send_tick(input bas_pkg::in_item_t tick, input logic typed,
                           input bas_pkg::out_item_t want);
    bas_pkg::out_item_t predicted;
    tick_ch.data <= tick;
    tick_ch.valid <= 1'b1;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_taken++;
    advance_selector(tick, predicted);
    screen_states_due.push_back(typed ? want : predicted);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected screen state has come back.
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (screen_states_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bas_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bas_pkg::REG_DEBOUNCE_TIME:   debounce_ms = data;
      bas_pkg::REG_SHORT_PRESS_MAX: short_max_ms = data;
      bas_pkg::REG_BRIGHTNESS_MIN:  bright_min_ms = data;
      bas_pkg::REG_DIAGNOSTICS_MIN: diag_min_ms = data;
      bas_pkg::REG_TOUCH_ENABLED:   touch_on = data[0];
      bas_pkg::REG_ZONE_ENTER:      enter_lvl = int'(data[14:0]);
      bas_pkg::REG_ZONE_EXIT:       exit_lvl = int'(data[14:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] short_max,
                                input logic [15:0] bright, input logic [15:0] diag,
                                input logic touch, input logic [14:0] enter,
                                input logic [14:0] leave);
    write_reg(bas_pkg::REG_DEBOUNCE_TIME, deb);
    write_reg(bas_pkg::REG_SHORT_PRESS_MAX, short_max);
    write_reg(bas_pkg::REG_BRIGHTNESS_MIN, bright);
    write_reg(bas_pkg::REG_DIAGNOSTICS_MIN, diag);
    write_reg(bas_pkg::REG_TOUCH_ENABLED, {15'd0, touch});
    write_reg(bas_pkg::REG_ZONE_ENTER, {1'b0, enter});
    write_reg(bas_pkg::REG_ZONE_EXIT, {1'b0, leave});
    cfg_we <= 1'b0;
  endtask

  // Random tick: button held in runs with occasional bounces, aux often near the thresholds.
  task automatic next_random_tick(output bas_pkg::in_item_t t);
    int pick;
    int p;
    pick = $urandom_range(0, 99);
    if (pick < 40) tick_now_ms = tick_now_ms + $urandom_range(1, 10);
    else if (pick < 80) tick_now_ms = tick_now_ms + $urandom_range(11, 250);
    else if (pick < 97) tick_now_ms = tick_now_ms + $urandom_range(251, 2500);
    else tick_now_ms = tick_now_ms + $urandom;
    t.time_ms = tick_now_ms;

    if (press_left == 0) begin
      plan_level = ~plan_level;
      press_left = $urandom_range(1, 25);
    end
    press_left--;
    t.button_level = ($urandom_range(0, 11) == 0) ? ~plan_level : plan_level;

    t.touch_request = ($urandom_range(0, 4) == 0);
    t.touch_target = 2'($urandom_range(0, 3));
    t.vehicle_valid = ($urandom_range(0, 3) != 0);
    t.radio_lost = ($urandom_range(0, 15) == 0);

    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      p = aux_last + int'($urandom_range(0, 2000)) - 1000;
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: p = enter_lvl;
        1: p = -enter_lvl;
        2: p = exit_lvl;
        default: p = -exit_lvl;
      endcase
      p = p + int'($urandom_range(0, 4)) - 2;
    end else if (pick < 72) begin
      case ($urandom_range(0, 4))
        0: p = -32768;
        1: p = -32767;
        2: p = 32767;
        3: p = 0;
        default: p = -1;
      endcase
    end else begin
      p = int'($signed(16'($urandom)));
    end
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    aux_last = p;
    t.aux_position = 16'(p);
  endtask

  // Result receiver: random stall bursts plus one long hold-off to back the block up.
  initial begin
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && ticks_taken >= HOLD_AT_TICK) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Compare each reported screen state with the oldest one expected.
  always @(posedge clk) begin : result_check
    bas_pkg::out_item_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (screen_states_due.size() == 0) begin
        $error("screen state reported with none expected");
        fail_count++;
      end else begin
        want = screen_states_due.pop_front();
        check_field("page", want.page, result_ch.data.page);
        check_field("brightness_pulse", 2'(want.brightness_pulse),
                    2'(result_ch.data.brightness_pulse));
        check_field("diagnostics_pulse", 2'(want.diagnostics_pulse),
                    2'(result_ch.data.diagnostics_pulse));
        check_field("aux_in_control", 2'(want.aux_in_control),
                    2'(result_ch.data.aux_in_control));
        check_field("button_stable", 2'(want.button_stable),
                    2'(result_ch.data.button_stable));
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    dir_row_t          rows[$];
    bas_pkg::in_item_t tick;
    dir_row_t          d;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= bas_pkg::REG_DEBOUNCE_TIME;
    cfg_wdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data <= '0;
    ticks_taken = 0;
    idle_pct = 20;

    // Model state after reset.
    debounce_ms = bas_pkg::DEBOUNCE_TIME_RST;
    short_max_ms = bas_pkg::SHORT_PRESS_MAX_RST;
    bright_min_ms = bas_pkg::BRIGHTNESS_MIN_RST;
    diag_min_ms = bas_pkg::DIAGNOSTICS_MIN_RST;
    touch_on = bas_pkg::TOUCH_ENABLED_RST;
    enter_lvl = int'(bas_pkg::ZONE_ENTER_RST);
    exit_lvl = int'(bas_pkg::ZONE_EXIT_RST);
    sel_page = bas_pkg::PAGE_DASHBOARD;
    sel_zone = bas_pkg::ZONE_UNKNOWN;
    btn_raw = 1'b0;
    btn_stable = 1'b0;
    raw_edge_ms = '0;
    press_start_ms = '0;
    aux_owns = 1'b0;

    // Directed table, run with the reset register values.
    // Idle tick right after reset.
    rows.push_back(row(32'd0, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0,
                       1'b1, bas_pkg::PAGE_DASHBOARD, 1'b0, 1'b0, 1'b0, 1'b0));
    // Short press: cycles dashboard to face.
    rows.push_back(row(32'd5, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd35, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd100, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd130, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    // Touch request while touch is disabled is ignored.
    rows.push_back(row(32'd140, 1'b0, 1'b1, bas_pkg::PAGE_SHOWCASE, 1'b0, 1'b0, 16'sd0));
    // Press of exactly the brightness minimum.
    rows.push_back(row(32'd200, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd230, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd2200, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd2230, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    // Press of exactly the diagnostics minimum.
    rows.push_back(row(32'd3000, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd3030, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd8000, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd8030, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    // Press between the short maximum and the brightness minimum does nothing.
    rows.push_back(row(32'd9000, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd9030, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd10030, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'd10060, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    // Aux channel: first sample in mid, then both extremes take control.
    rows.push_back(row(32'd10200, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, 16'sd0));
    rows.push_back(row(32'd10201, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, 16'h7FFF,
                       1'b1, bas_pkg::PAGE_SHOWCASE, 1'b0, 1'b0, 1'b1, 1'b0));
    rows.push_back(row(32'd10202, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, 16'h8000,
                       1'b1, bas_pkg::PAGE_DASHBOARD, 1'b0, 1'b0, 1'b1, 1'b0));
    // Just inside the exit level falls back to mid; then link loss releases control.
    rows.push_back(row(32'd10203, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, -16'sd8846));
    rows.push_back(row(32'd10204, 1'b0, 1'b0, 2'd0, 1'b1, 1'b1, 16'h7FFF));
    // Press across the wrap of the millisecond counter.
    rows.push_back(row(32'hFFFF_FFF0, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'h0000_000E, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'h0000_0100, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));
    rows.push_back(row(32'h0000_011E, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 16'sd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      d = rows[i];
      send_tick(d.tick, d.typed, d.want);
    end

    // Random streams, one register setting per phase.
    tick_now_ms = 32'h0000_0200;
    plan_level = 1'b0;
    press_left = 0;
    aux_last = 0;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      idle_pct = $urandom_range(5, 35);
      case (phase)
        0: ;
        1: apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 15'd0, 15'd0);
        2: apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1, 15'h7FFF, 15'h7FFF);
        3: apply_settings(16'd10, 16'd500, 16'd1000, 16'd3000, 1'b1, 15'd8000, 15'd12000);
        4: apply_settings(16'($urandom_range(0, 100)), 16'($urandom_range(0, 1500)),
                          16'($urandom_range(0, 4000)), 16'($urandom_range(0, 8000)),
                          1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)),
                          15'($urandom_range(0, 32767)));
        default: begin
          apply_settings(bas_pkg::DEBOUNCE_TIME_RST, bas_pkg::SHORT_PRESS_MAX_RST,
                         bas_pkg::BRIGHTNESS_MIN_RST, bas_pkg::DIAGNOSTICS_MIN_RST, 1'b1,
                         bas_pkg::ZONE_ENTER_RST, bas_pkg::ZONE_EXIT_RST);
          // Last stretch runs at full rate on both sides.
          idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        next_random_tick(tick);
        send_tick(tick, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && screen_states_due.size() == 0) begin
      $display("button_aux_page_selector_tb passed");
    end else begin
      $display("button_aux_page_selector_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bas_pkg.sv
rtl/bas_in_if.sv
rtl/bas_out_if.sv
rtl/button_aux_page_selector.sv
dv/button_aux_page_selector_tb.sv
